// ===== hw/rtl/rpp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpp_pkg: shared types and constants
// Register map codes, configuration record and queue entry for the
// rectangle perimeter path generator.
// ----------------------------------------------------------------------------
package rpp_pkg;

  localparam int TIME_W   = 32;  // sample time, Q16.16
  localparam int LEN_W    = 20;  // width, height, speed
  localparam int PERIM_W  = 22;  // perimeter
  localparam int ROW_W    = 48;  // three packed Q1.14 coefficients
  localparam int COEF_W   = 16;
  localparam int OFF_W    = 63;  // three packed translations
  localparam int TRANS_W  = 21;
  localparam int POS_W    = 24;  // saturated result, Q7.16
  localparam int PY_W     = 24;  // plane y, may go negative on the left edge
  localparam int ROT_FRAC = 14;
  localparam int M1_W     = COEF_W + LEN_W + 1;  // coef * px
  localparam int M2_W     = COEF_W + PY_W;       // coef * py
  localparam int ACC_W    = M2_W + 1;
  localparam int SUM_W    = ACC_W - ROT_FRAC + 1;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;

  typedef enum logic [2:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_PERIM,
    REG_SPEED,
    REG_ROT_X,
    REG_ROT_Y,
    REG_ROT_Z,
    REG_OFFSET
  } rpp_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0]   width;
    logic [LEN_W-1:0]   height;
    logic [PERIM_W-1:0] perim;
    logic [LEN_W-1:0]   speed;
    logic [ROW_W-1:0]   rot_x;
    logic [ROW_W-1:0]   rot_y;
    logic [ROW_W-1:0]   rot_z;
    logic [OFF_W-1:0]   offset;
  } rpp_cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0]        px;
    logic signed [PY_W-1:0]  py;
  } rpp_pt_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rectangle_perimeter_path.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rectangle_perimeter_path: rectangular trajectory generator
// Maps a time stamp to a rotated, translated point on a rectangle's edge.
// ----------------------------------------------------------------------------
// Each accepted time stamp yields one (x, y, z) point, one transaction per
// clock in both directions unless a stall holds it. The distance
// time*speed is reduced modulo the perimeter by a pipelined restoring
// remainder that takes one quotient bit per stage. From input to output
// a point passes the multiply, the remainder stages, the edge walk, the
// queue, the products and the round and clamp. A four-entry queue
// separates the distance front from the projection back; each side holds
// on its own stall. Registers sit at byte address 8*index on the 64-bit
// APB port and must be written only while the block is idle.
module rectangle_perimeter_path #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rpp_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [rpp_pkg::DATA_W-1:0]    pwdata,
  output logic [rpp_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  // time stamps in
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rpp_pkg::TIME_W-1:0]    in_sample_time,
  // points out
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rpp_pkg::POS_W-1:0]          out_pos_x,
  output logic [rpp_pkg::POS_W-1:0]          out_pos_y,
  output logic [rpp_pkg::POS_W-1:0]          out_pos_z
);
  import rpp_pkg::*;

  rpp_cfg_t cfg_r, cfg_nxt;
  rpp_reg_t reg_sel;
  logic     wr_en;
  logic     q_full, q_empty, q_push, q_pop;
  rpp_pt_t  q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_sel = rpp_reg_t'(paddr[ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  // register write: truncate to the register width
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_WIDTH:  cfg_nxt.width  = pwdata[LEN_W-1:0];
        REG_HEIGHT: cfg_nxt.height = pwdata[LEN_W-1:0];
        REG_PERIM:  cfg_nxt.perim  = pwdata[PERIM_W-1:0];
        REG_SPEED:  cfg_nxt.speed  = pwdata[LEN_W-1:0];
        REG_ROT_X:  cfg_nxt.rot_x  = pwdata[ROW_W-1:0];
        REG_ROT_Y:  cfg_nxt.rot_y  = pwdata[ROW_W-1:0];
        REG_ROT_Z:  cfg_nxt.rot_z  = pwdata[ROW_W-1:0];
        REG_OFFSET: cfg_nxt.offset = pwdata[OFF_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // readback
  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = DATA_W'(cfg_r.width);
      REG_HEIGHT: prdata = DATA_W'(cfg_r.height);
      REG_PERIM:  prdata = DATA_W'(cfg_r.perim);
      REG_SPEED:  prdata = DATA_W'(cfg_r.speed);
      REG_ROT_X:  prdata = DATA_W'(cfg_r.rot_x);
      REG_ROT_Y:  prdata = DATA_W'(cfg_r.rot_y);
      REG_ROT_Z:  prdata = DATA_W'(cfg_r.rot_z);
      REG_OFFSET: prdata = DATA_W'(cfg_r.offset);
      default:    prdata = '0;
    endcase
  end

  rpp_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_time (in_sample_time),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  rpp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  rpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/rpp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpp_front: distance and edge walk
// Multiplies time by speed, reduces modulo the perimeter one quotient bit
// per stage, and places the distance on the rectangle's edges.
// ----------------------------------------------------------------------------
module rpp_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rpp_pkg::rpp_cfg_t         cfg,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [rpp_pkg::TIME_W-1:0] in_sample_time,
  input  wire logic                      q_full,
  output logic                           q_push,
  output rpp_pkg::rpp_pt_t               q_data
);
  import rpp_pkg::*;

  localparam int PROD_W = TIME_W + LEN_W;
  localparam int QW     = PROD_W - FRAC_BITS;
  localparam int RW     = PERIM_W + 1;

  logic              vld_r [0:QW];
  logic [RW-1:0]     rem_r [0:QW];
  logic [QW-1:0]     qs_r  [0:QW-1];
  logic [PROD_W-1:0] prod_nxt;
  logic [RW-1:0]     perim_ext;
  logic              adv;
  logic              vw_r;
  rpp_pt_t           pt_r;
  rpp_pt_t           pt_nxt;

  assign perim_ext = RW'(cfg.perim);
  assign adv       = !vw_r || !q_full;
  assign in_stall  = !adv;
  assign q_push    = vw_r && !q_full;
  assign q_data    = pt_r;
  assign prod_nxt  = PROD_W'(in_sample_time) * PROD_W'(cfg.speed);

  // time * speed, already shifted down to a length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
    if (adv) begin
      rem_r[0] <= '0;
      qs_r[0]  <= prod_nxt[PROD_W-1:FRAC_BITS];
    end
  end

  // restoring remainder, one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_mod
    logic [RW-1:0] trial;
    assign trial = {rem_r[k-1][RW-2:0], qs_r[k-1][QW-1]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
      if (adv) begin
        rem_r[k] <= (trial >= perim_ext) ? trial - perim_ext : trial;
      end
    end
    if (k < QW) begin : g_q
      always_ff @(posedge clk) begin
        if (adv) begin
          qs_r[k] <= qs_r[k-1] << 1;
        end
      end
    end
  end

  // edge walk: bottom, right, top, then whatever is left on the left edge
  always_comb begin
    logic [PERIM_W-1:0] d;
    logic [PY_W-1:0]    d24, c1, c2, c3, c4;
    d   = (cfg.perim == '0 || cfg.speed == '0) ? '0 : rem_r[QW][PERIM_W-1:0];
    d24 = PY_W'(d);
    c1  = PY_W'(cfg.width);
    c2  = c1 + PY_W'(cfg.height);
    c3  = c2 + c1;
    c4  = c3 + PY_W'(cfg.height);
    if (d24 < c1) begin
      pt_nxt.px = d24[LEN_W-1:0];
      pt_nxt.py = '0;
    end else if (d24 < c2) begin
      pt_nxt.px = cfg.width;
      pt_nxt.py = d24 - c1;
    end else if (d24 < c3) begin
      pt_nxt.px = LEN_W'(c3 - d24);
      pt_nxt.py = PY_W'(cfg.height);
    end else begin
      pt_nxt.px = '0;
      pt_nxt.py = c4 - d24;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= 1'b0;
    end else if (adv) begin
      vw_r <= vld_r[QW];
    end
    if (adv) begin
      pt_r <= pt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rpp_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpp_fifo: plane point queue
// Short queue between the distance front and the projection back.
// ----------------------------------------------------------------------------
module rpp_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire rpp_pkg::rpp_pt_t push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output rpp_pkg::rpp_pt_t      pop_data
);
  import rpp_pkg::*;

  rpp_pt_t           ent_r [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rpp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpp_back: rotation, translation and saturation
// Two stages: products, then round, offset and clamp into the output
// register.
// ----------------------------------------------------------------------------
module rpp_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire rpp_pkg::rpp_cfg_t        cfg,
  input  wire logic                     q_empty,
  input  wire rpp_pkg::rpp_pt_t         q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [rpp_pkg::POS_W-1:0]     out_pos_x,
  output logic [rpp_pkg::POS_W-1:0]     out_pos_y,
  output logic [rpp_pkg::POS_W-1:0]     out_pos_z
);
  import rpp_pkg::*;

  logic                   va_r, vb_r, adv;
  logic signed [M1_W-1:0] m1_r [0:2];
  logic signed [M2_W-1:0] m2_r [0:2];
  logic [POS_W-1:0]       pos_r [0:2];
  logic [ROW_W-1:0]       rows [0:2];
  logic [TRANS_W-1:0]     offs [0:2];

  function automatic logic [POS_W-1:0] proj(input logic signed [M1_W-1:0] a,
                                            input logic signed [M2_W-1:0] b,
                                            input logic [TRANS_W-1:0] o);
    logic signed [ACC_W-1:0] acc;
    logic signed [SUM_W-1:0] s;
    acc = ACC_W'(a) + ACC_W'(b) + ACC_W'(1 << (ROT_FRAC - 1));
    s   = SUM_W'(signed'(acc[ACC_W-1:ROT_FRAC])) + SUM_W'(signed'(o));
    if (s > SUM_W'(signed'({1'b0, {(POS_W-1){1'b1}}}))) begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end else if (s < SUM_W'(signed'({1'b1, {(POS_W-1){1'b0}}}))) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end
    return s[POS_W-1:0];
  endfunction

  assign rows[0] = cfg.rot_x;
  assign rows[1] = cfg.rot_y;
  assign rows[2] = cfg.rot_z;
  assign offs[0] = cfg.offset[TRANS_W-1:0];
  assign offs[1] = cfg.offset[2*TRANS_W-1:TRANS_W];
  assign offs[2] = cfg.offset[3*TRANS_W-1:2*TRANS_W];

  assign adv       = !vb_r || !out_stall;
  assign q_pop     = adv && !q_empty;
  assign out_valid = vb_r;
  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= !q_empty;
      vb_r <= va_r;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk) begin
      if (adv) begin
        m1_r[r]  <= signed'(rows[r][COEF_W-1:0]) * signed'({1'b0, q_data.px});
        m2_r[r]  <= signed'(rows[r][2*COEF_W-1:COEF_W]) * q_data.py;
        pos_r[r] <= proj(m1_r[r], m2_r[r], offs[r]);
      end
    end
  end

endmodule
`default_nettype wire
